// ===== sv/arp_nh_pkg.sv =====
package arp_nh_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned TDATA_W     = 80;  // address and mac, whole bytes
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TUSER_W = 4;
  localparam int unsigned ENTRY_W     = ADDR_W + MAC_W;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_ADDRESS = 2'd2;

  localparam logic [ADDR_W-1:0] LOCAL_ADDRESS_RST   = 32'hC0A8_0164;
  localparam logic [ADDR_W-1:0] SUBNET_MASK_RST     = 32'hFFFF_FF00;
  localparam logic [ADDR_W-1:0] GATEWAY_ADDRESS_RST = 32'hC0A8_0101;

  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  // result tuser bit positions
  localparam int unsigned U_HIT     = 0;
  localparam int unsigned U_REQUEST = 1;
  localparam int unsigned U_STORED  = 2;
  localparam int unsigned U_FULL    = 3;

  typedef enum logic {
    MODE_RESOLVE = 1'b0,
    MODE_ADD     = 1'b1
  } mode_e;

  // classified item: addr is the next hop for a resolve, the new entry ip for an add
  typedef struct packed {
    mode_e             mode;
    logic [ADDR_W-1:0] addr;
    logic [MAC_W-1:0]  mac;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/arp_nh_ram.sv =====
module arp_nh_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/arp_nh_queue.sv =====
module arp_nh_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  arp_nh_pkg::item_t     push_item_i,
  input  logic                  pop_i,
  output arp_nh_pkg::item_t     head_o,
  output arp_nh_pkg::q_status_t status_o
);

  localparam int unsigned PTR_W = (arp_nh_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(arp_nh_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(arp_nh_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(arp_nh_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(arp_nh_pkg::QUEUE_DEPTH);

  arp_nh_pkg::item_t mem_q [arp_nh_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == FULL_CNT);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/arp_nh_front.sv =====
module arp_nh_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [arp_nh_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [arp_nh_pkg::ADDR_W-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [arp_nh_pkg::TDATA_W-1:0]      in_data_i,
  input  logic [arp_nh_pkg::IN_TUSER_W-1:0]   in_user_i,
  output logic                                push_o,
  output arp_nh_pkg::item_t                   push_item_o,
  input  arp_nh_pkg::q_status_t               q_status_i
);

  logic [arp_nh_pkg::ADDR_W-1:0] local_q, mask_q, gateway_q;
  logic [arp_nh_pkg::ADDR_W-1:0] dest;
  logic [arp_nh_pkg::ADDR_W-1:0] hop;
  arp_nh_pkg::mode_e             mode;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q   <= arp_nh_pkg::LOCAL_ADDRESS_RST;
      mask_q    <= arp_nh_pkg::SUBNET_MASK_RST;
      gateway_q <= arp_nh_pkg::GATEWAY_ADDRESS_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == arp_nh_pkg::REG_LOCAL_ADDRESS) begin
        local_q <= cfg_data_i;
      end
      if (cfg_index_i == arp_nh_pkg::REG_SUBNET_MASK) begin
        mask_q <= cfg_data_i;
      end
      if (cfg_index_i == arp_nh_pkg::REG_GATEWAY_ADDRESS) begin
        gateway_q <= cfg_data_i;
      end
    end
  end

  assign mode = arp_nh_pkg::mode_e'(in_user_i[0]);
  assign dest = in_data_i[arp_nh_pkg::ADDR_W-1:0];
  // off-subnet destinations resolve through the gateway
  assign hop  = ((dest & mask_q) != (local_q & mask_q)) ? gateway_q : dest;

  assign in_ready_o       = !q_status_i.full;
  assign push_o           = in_valid_i && !q_status_i.full;
  assign push_item_o.mode = mode;
  assign push_item_o.addr = (mode == arp_nh_pkg::MODE_ADD) ? dest : hop;
  assign push_item_o.mac  = in_data_i[arp_nh_pkg::TDATA_W-1:arp_nh_pkg::ADDR_W];

endmodule

// ===== sv/arp_nh_back.sv =====
module arp_nh_back #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  output logic                                pop_o,
  input  arp_nh_pkg::item_t                   head_i,
  input  arp_nh_pkg::q_status_t               q_status_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [arp_nh_pkg::TDATA_W-1:0]      out_data_o,
  output logic [arp_nh_pkg::OUT_TUSER_W-1:0]  out_user_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                               state_q, state_d;
  logic [CW-1:0]                      fill_q, fill_d;
  logic [CW-1:0]                      idx_q, idx_d;
  logic                               pend_q, pend_d;
  logic [arp_nh_pkg::ADDR_W-1:0]      hop_q, hop_d;
  logic                               out_valid_q;
  logic [arp_nh_pkg::TDATA_W-1:0]     out_data_q, res_data;
  logic [arp_nh_pkg::OUT_TUSER_W-1:0] out_user_q, res_user;
  logic                               out_free, load_out;
  logic                               ram_we, ram_re, rd_en, match;
  logic [arp_nh_pkg::ENTRY_W-1:0]     ram_rdata;

  arp_nh_ram #(
    .WIDTH (arp_nh_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i ({head_i.mac, head_i.addr}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_status_i.empty && out_free;
  assign rd_en    = idx_q < fill_q;
  assign ram_re   = (state_q == ST_SCAN) && rd_en;
  // read data is registered: it arrives in the cycle after its index is issued
  assign match    = pend_q && (ram_rdata[arp_nh_pkg::ADDR_W-1:0] == hop_q);

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    hop_d    = hop_q;
    load_out = 1'b0;
    ram_we   = 1'b0;
    res_data = '0;
    res_user = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          if (head_i.mode == arp_nh_pkg::MODE_ADD) begin
            load_out = 1'b1;
            if (fill_q == DEPTH_CNT) begin
              res_user[arp_nh_pkg::U_FULL] = 1'b1;
            end else begin
              ram_we = 1'b1;
              fill_d = fill_q + CW'(1);
              res_user[arp_nh_pkg::U_STORED] = 1'b1;
            end
          end else begin
            state_d = ST_SCAN;
            idx_d   = '0;
            pend_d  = 1'b0;
            hop_d   = head_i.addr;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          load_out = 1'b1;
          res_data = {ram_rdata[arp_nh_pkg::ENTRY_W-1:arp_nh_pkg::ADDR_W], hop_q};
          res_user[arp_nh_pkg::U_HIT] = 1'b1;
          state_d  = ST_IDLE;
          pend_d   = 1'b0;
        end else if (!rd_en && !pend_q) begin
          load_out = 1'b1;
          res_data = {arp_nh_pkg::BCAST_MAC, hop_q};
          res_user[arp_nh_pkg::U_REQUEST] = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          pend_d = rd_en;
          idx_d  = idx_q + CW'(rd_en);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hop_q <= hop_d;
    if (load_out) begin
      out_data_q <= res_data;
      out_user_q <= res_user;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_CNT)
    else $error("fill count beyond table depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result loaded over a pending result");

  a_scan_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !out_valid_q)
    else $error("output slot busy during a scan");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (fill_q == $past(fill_q) + CW'(1)))
    else $error("table write without fill count advance");

endmodule

// ===== sv/arp_cache_next_hop_resolver.sv =====
// ARP cache with next-hop selection.
// Input stream s_axis: tuser[0] is the mode (0 resolve, 1 add); tdata carries the
// target ip in [31:0] and the entry mac in [79:32]. Output stream m_axis: tdata has
// next_hop [31:0] and resolved_mac [79:32]; tuser has hit, request_needed, stored
// and full_res from bit 0 up. One result per input item, in input order.
// Configuration channel: cfg_index_i 0 local address, 1 subnet mask, 2 gateway;
// other indexes are ignored. Write it only while the block is idle.
// An add goes through the queue to the table write and the output register. A resolve
// scans the table through the single read port of the entry memory, one entry per
// cycle, from the oldest: the first match ends the scan with a hit, a miss ends it
// once every entry below the fill count has been read. Items are carried out one at
// a time.
// A two-entry queue between the classifying front and the table engine keeps
// accepting input while a lookup runs; a result waiting on m_axis_tready stalls the
// engine only, the front keeps filling the queue until it is full.
// Reset clears the fill count, the queue and the output slot and restores the
// register defaults; the table itself is not cleared, entries are read only below
// the fill count.
module arp_cache_next_hop_resolver #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [arp_nh_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [arp_nh_pkg::ADDR_W-1:0]       cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // target_address [31:0], entry_mac [79:32]
  input  logic [arp_nh_pkg::TDATA_W-1:0]      s_axis_tdata,
  // mode [0]
  input  logic [arp_nh_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // next_hop [31:0], resolved_mac [79:32]
  output logic [arp_nh_pkg::TDATA_W-1:0]      m_axis_tdata,
  // hit [0], request_needed [1], stored [2], full_res [3]
  output logic [arp_nh_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

  logic                  push, pop;
  arp_nh_pkg::item_t     push_item, head;
  arp_nh_pkg::q_status_t q_status;

  arp_nh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .push_o      (push),
    .push_item_o (push_item),
    .q_status_i  (q_status)
  );

  arp_nh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  arp_nh_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .head_i      (head),
    .q_status_i  (q_status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule
